>>> rtl/core/pressure_temperature_compensation_top_assert.svh
// Assertion macros for the compensation core
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH

// Antecedent in this cycle implies consequent in the same cycle
`define PTC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ptc_pkg.sv
package ptc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgTemp      = 2'd0;
  localparam logic [1:0] CfgPressLow  = 2'd1;
  localparam logic [1:0] CfgPressHigh = 2'd2;
  localparam logic [1:0] CfgPressNine = 2'd3;

  // Fixed constants of the compensation formula
  localparam logic [63:0] FineOffset = 64'd128000;
  localparam logic [63:0] RawFull    = 64'd1048576;
  localparam logic [63:0] PressScale = 64'd3125;
  localparam logic [63:0] Bias47     = 64'h0000_8000_0000_0000;
  localparam logic [31:0] Round128   = 32'd128;

  // Divider stages, one quotient bit each
  localparam int unsigned DivBits = 64;

  // Side data that travels with an item through the divider
  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] tf;
    logic        zero;
  } ptc_tag_t;

  // Sign-extend a 16-bit coefficient to 64 bits
  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

endpackage

>>> rtl/core/pressure_temperature_compensation_top.sv
// Throughput: one request per cycle; busy_o never rises and done_o needs no ack.
// The 64-stage pipelined divider, one quotient bit a stage, sets the latency.
// Reset clears the coefficients and all valid bits; data registers are not reset.
// Results cannot be stalled by the receiver.
module pressure_temperature_compensation_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [19:0]        raw_temperature_i,
  input  logic [19:0]        raw_pressure_i,
  output logic               done_o,
  output logic signed [31:0] temperature_centi_o,
  output logic signed [31:0] fine_temperature_o,
  output logic [31:0]        pressure_pa_o,
  output logic               divisor_zero_o
);
  import ptc_pkg::*;

  `include "pressure_temperature_compensation_top_assert.svh"

  localparam int unsigned Latency = 86;

  // Coefficient registers
  logic [47:0] temp_coeffs_q;
  logic [63:0] press_low_q;
  logic [63:0] press_high_q;
  logic [15:0] press_nine_q;

  logic        acc;
  logic [13:1] vld_q;
  logic [19:0] ad_q [1:10];
  ptc_tag_t    tt_q [5:13];

  logic [31:0] a_q, b_q, mat_q, mbb_q, v1t_q, x_q, tf_q;
  logic [63:0] v1_q, v1p5_q [8:9], v1p2_q [8:9];
  logic [63:0] v2_q, v1bb_q, pn_q, v1c_q;
  logic [63:0] v1sq_w, v1p5_w, v1p2_w, d_w, e_w, f_w, n_w;

  logic [31:0] t1x, t2x, t3x, bbs_d, tc_d;
  ptc_tag_t    div_tag_d;

  logic        dv_vld;
  logic [63:0] dv_quo;
  ptc_tag_t    dv_tag;

  logic [7:1]  pv_q;
  ptc_tag_t    pt_q [1:6];
  logic [63:0] pc_q [1:4];
  logic [63:0] pp8_q [3:4];
  logic [63:0] sum3_q, pf_q, pfb_d;
  logic [63:0] q_d, qq_w, pp8_w, j_w;

  logic [31:0] tc_out_q, tf_out_q, pa_q;
  logic        zero_out_q;

  // Accept every request; the pipeline never stalls
  assign busy_o = 1'b0;
  assign acc    = start_i && !busy_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_low_q   <= '0;
      press_high_q  <= '0;
      press_nine_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTemp:      temp_coeffs_q <= cfg_data_i[47:0];
        CfgPressLow:  press_low_q   <= cfg_data_i;
        CfgPressHigh: press_high_q  <= cfg_data_i;
        CfgPressNine: press_nine_q  <= cfg_data_i[15:0];
        default:      ;
      endcase
    end
  end

  // Advance the valid bits ahead of the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[12:1], acc};
    end
  end

  // Temperature coefficients, widened to 32 bits
  assign t1x = {16'd0, temp_coeffs_q[15:0]};
  assign t2x = {{16{temp_coeffs_q[31]}}, temp_coeffs_q[31:16]};
  assign t3x = {{16{temp_coeffs_q[47]}}, temp_coeffs_q[47:32]};

  assign bbs_d = 32'($signed(mbb_q) >>> 12);
  assign tc_d  = 32'($signed(tf_q + (tf_q << 2) + Round128) >>> 8);

  // Temperature path, 32-bit wrapping
  always_ff @(posedge clk_i) begin
    a_q   <= {15'd0, raw_temperature_i[19:3]} - (t1x << 1);
    b_q   <= {16'd0, raw_temperature_i[19:4]} - t1x;
    mat_q <= a_q * t2x;
    mbb_q <= b_q * b_q;
    v1t_q <= 32'($signed(mat_q) >>> 11);
    x_q   <= bbs_d * t3x;
    tf_q  <= v1t_q + 32'($signed(x_q) >>> 14);
    v1_q  <= {{32{tf_q[31]}}, tf_q} - FineOffset;
  end

  // Carry the raw pressure and temperature results alongside
  always_ff @(posedge clk_i) begin
    ad_q[1] <= raw_pressure_i;
    for (int k = 2; k <= 10; k++) begin
      ad_q[k] <= ad_q[k-1];
    end
    tt_q[5] <= '{tc: tc_d, tf: tf_q, zero: 1'b0};
    for (int k = 6; k <= 13; k++) begin
      tt_q[k] <= tt_q[k-1];
    end
  end

  // Pressure path multiplies, each through a pipelined ptc_mul64
  ptc_mul64 u_mul_v1sq (.clk_i, .a_i(v1_q), .b_i(v1_q), .p_o(v1sq_w));
  ptc_mul64 u_mul_v1p5 (.clk_i, .a_i(v1_q), .b_i(sx16(press_high_q[15:0])), .p_o(v1p5_w));
  ptc_mul64 u_mul_v1p2 (.clk_i, .a_i(v1_q), .b_i(sx16(press_low_q[31:16])), .p_o(v1p2_w));
  ptc_mul64 u_mul_p6   (.clk_i, .a_i(v1sq_w), .b_i(sx16(press_high_q[31:16])), .p_o(d_w));
  ptc_mul64 u_mul_p3   (.clk_i, .a_i(v1sq_w), .b_i(sx16(press_low_q[47:32])), .p_o(e_w));
  ptc_mul64 u_mul_p1   (.clk_i, .a_i(v1bb_q), .b_i({48'd0, press_low_q[15:0]}), .p_o(f_w));
  ptc_mul64 u_mul_sc   (.clk_i, .a_i(pn_q), .b_i(PressScale), .p_o(n_w));

  // Combine the correction terms
  always_ff @(posedge clk_i) begin
    v1p5_q[8] <= v1p5_w;
    v1p5_q[9] <= v1p5_q[8];
    v1p2_q[8] <= v1p2_w;
    v1p2_q[9] <= v1p2_q[8];
    v2_q      <= d_w + (v1p5_q[9] << 17) + (sx16(press_low_q[63:48]) << 35);
    v1bb_q    <= Bias47 + 64'($signed(e_w) >>> 8) + (v1p2_q[9] << 12);
    pn_q      <= ((RawFull - {44'd0, ad_q[10]}) << 31) - v2_q;
    v1c_q     <= 64'($signed(f_w) >>> 33);
  end

  // Flag a zero divisor on entry to the divider
  always_comb begin
    div_tag_d      = tt_q[13];
    div_tag_d.zero = (v1c_q == 64'd0);
  end

  ptc_div64 u_div (
    .clk_i,
    .rst_ni,
    .valid_i (vld_q[13]),
    .num_i   (n_w),
    .den_i   (v1c_q),
    .tag_i   (div_tag_d),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .tag_o   (dv_tag)
  );

  // Second-order pressure correction
  assign q_d = 64'($signed(dv_quo) >>> 13);

  ptc_mul64 u_mul_qq  (.clk_i, .a_i(q_d), .b_i(q_d), .p_o(qq_w));
  ptc_mul64 u_mul_p8  (.clk_i, .a_i(dv_quo), .b_i(sx16(press_high_q[63:48])), .p_o(pp8_w));
  ptc_mul64 u_mul_p9  (.clk_i, .a_i(qq_w), .b_i(sx16(press_nine_q)), .p_o(j_w));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      pv_q <= {pv_q[6:1], dv_vld};
    end
  end

  assign pfb_d = pf_q + (pf_q[63] ? 64'd255 : 64'd0);

  always_ff @(posedge clk_i) begin
    pt_q[1] <= dv_tag;
    pc_q[1] <= dv_quo;
    for (int k = 2; k <= 6; k++) begin
      pt_q[k] <= pt_q[k-1];
    end
    for (int k = 2; k <= 4; k++) begin
      pc_q[k] <= pc_q[k-1];
    end
    pp8_q[3] <= pp8_w;
    pp8_q[4] <= pp8_q[3];
    sum3_q   <= pc_q[4] + 64'($signed(j_w) >>> 25) + 64'($signed(pp8_q[4]) >>> 19);
    pf_q     <= 64'($signed(sum3_q) >>> 8) + (sx16(press_high_q[47:32]) << 4);
    // Truncate toward zero by 256 and drop to 32 bits
    tc_out_q   <= pt_q[6].tc;
    tf_out_q   <= pt_q[6].tf;
    zero_out_q <= pt_q[6].zero;
    pa_q       <= pt_q[6].zero ? 32'd0 : pfb_d[39:8];
  end

  assign done_o              = pv_q[7];
  assign temperature_centi_o = $signed(tc_out_q);
  assign fine_temperature_o  = $signed(tf_out_q);
  assign pressure_pa_o       = pa_q;
  assign divisor_zero_o      = zero_out_q;

  // Every result stems from a request accepted a fixed time before
  `PTC_ASSERT_IMPL(a_latency, done_o, $past(acc, Latency), "result without a request")
  // A zero divisor forces the pressure to zero
  `PTC_ASSERT_IMPL(a_zero_pa, done_o && divisor_zero_o, pressure_pa_o == 32'd0,
                   "pressure not cleared on zero divisor")
  // A request accepted now is marked valid at the front of the pipeline
  `PTC_ASSERT_NEXT(a_front, acc, vld_q[1], "request lost at entry")

endmodule

>>> rtl/core/ptc_mul64.sv
module ptc_mul64 (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_q;
  logic [31:0] lh_q;
  logic [31:0] hl_q;
  logic [63:0] p_q;
  logic [31:0] cross_d;

  // Form the partial products that reach the low 64 bits
  always_ff @(posedge clk_i) begin
    ll_q <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
    lh_q <= a_i[31:0] * b_i[63:32];
    hl_q <= a_i[63:32] * b_i[31:0];
  end

  // Sum the partials, wrapping to 64 bits
  assign cross_d = lh_q + hl_q;

  always_ff @(posedge clk_i) begin
    p_q <= ll_q + {cross_d, 32'd0};
  end

  assign p_o = p_q;

endmodule

>>> rtl/core/ptc_div64.sv
module ptc_div64 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [63:0]       num_i,
  input  logic [63:0]       den_i,
  input  ptc_pkg::ptc_tag_t tag_i,
  output logic              valid_o,
  output logic [63:0]       quo_o,
  output ptc_pkg::ptc_tag_t tag_o
);
  import ptc_pkg::*;

  logic        vld_q [0:DivBits];
  logic [63:0] rem_q [0:DivBits];
  logic [63:0] nq_q  [0:DivBits];
  logic [63:0] dv_q  [0:DivBits];
  logic        neg_q [0:DivBits];
  ptc_tag_t    tag_q [0:DivBits];

  logic        out_vld_q;
  logic [63:0] quo_q;
  ptc_tag_t    out_tag_q;

  // Take magnitudes and the sign of the quotient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= 64'd0;
    nq_q[0]  <= num_i[63] ? 64'd0 - num_i : num_i;
    dv_q[0]  <= den_i[63] ? 64'd0 - den_i : den_i;
    neg_q[0] <= num_i[63] ^ den_i[63];
    tag_q[0] <= tag_i;
  end

  // One restoring step per stage
  for (genvar k = 1; k <= DivBits; k++) begin : g_step
    logic [64:0] trial_d;
    logic [64:0] diff_d;
    logic        ge_d;

    assign trial_d = {rem_q[k-1], nq_q[k-1][63]};
    assign diff_d  = trial_d - {1'b0, dv_q[k-1]};
    assign ge_d    = !diff_d[64];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge_d ? diff_d[63:0] : trial_d[63:0];
      nq_q[k]  <= {nq_q[k-1][62:0], ge_d};
      dv_q[k]  <= dv_q[k-1];
      neg_q[k] <= neg_q[k-1];
      tag_q[k] <= tag_q[k-1];
    end
  end

  // Restore the sign, wrapping on overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[DivBits];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= neg_q[DivBits] ? 64'd0 - nq_q[DivBits] : nq_q[DivBits];
    out_tag_q <= tag_q[DivBits];
  end

  assign valid_o = out_vld_q;
  assign quo_o   = quo_q;
  assign tag_o   = out_tag_q;

endmodule

>>> dv/pressure_temperature_compensation_top_tb.sv
`timescale 1ns / 1ps

module pressure_temperature_compensation_top_tb;
  import ptc_pkg::*;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] fine_temp;
    logic [31:0] press_pa;
    logic        div_zero;
  } reading_t;

  localparam int unsigned SettleCycles = 90;
  localparam int unsigned CycleLimit   = 300000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgTemp;
  logic [63:0] cfg_data_i = '0;
  logic        start_i = 1'b0;
  logic [19:0] raw_temperature_i = '0;
  logic [19:0] raw_pressure_i = '0;
  logic        busy_o;
  logic        done_o;
  logic signed [31:0] temperature_centi_o;
  logic signed [31:0] fine_temperature_o;
  logic [31:0] pressure_pa_o;
  logic        divisor_zero_o;

  pressure_temperature_compensation_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start_i, .busy_o,
    .raw_temperature_i, .raw_pressure_i, .done_o, .temperature_centi_o,
    .fine_temperature_o, .pressure_pa_o, .divisor_zero_o
  );

  always #5 clk_i = ~clk_i;

  // Local copy of the calibration registers
  logic [47:0] temp_cal;
  logic [63:0] press_cal_low;
  logic [63:0] press_cal_high;
  logic [15:0] press_cal_nine;

  reading_t    pending_readings[$];
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned readings_seen;
  int unsigned zero_divisors;
  int unsigned idle_pct;
  int unsigned cycle_count;

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [63:0] sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Signed division truncating toward zero; most negative by -1 wraps
  function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] un, ud, q;
    un = n[63] ? -n : n;
    ud = d[63] ? -d : d;
    q  = un / ud;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp);
    logic [31:0] adct, t1, t2, t3, a, b, v1t, v2t, tf;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, p, q, w1, w2, pa;
    reading_t r;
    adct = {12'b0, rt};
    t1 = {16'b0, temp_cal[15:0]};
    t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
    t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
    a = (adct >> 3) - (t1 << 1);
    v1t = asr32(a * t2, 11);
    b = (adct >> 4) - t1;
    v2t = asr32(asr32(b * b, 12) * t3, 14);
    tf = v1t + v2t;
    r.fine_temp  = tf;
    r.temp_centi = asr32(tf * 32'd5 + 32'd128, 8);
    p1 = {48'b0, press_cal_low[15:0]};
    p2 = sext16(press_cal_low[31:16]);
    p3 = sext16(press_cal_low[47:32]);
    p4 = sext16(press_cal_low[63:48]);
    p5 = sext16(press_cal_high[15:0]);
    p6 = sext16(press_cal_high[31:16]);
    p7 = sext16(press_cal_high[47:32]);
    p8 = sext16(press_cal_high[63:48]);
    p9 = sext16(press_cal_nine);
    v1 = {{32{tf[31]}}, tf} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
    r.press_pa = '0;
    r.div_zero = (v1 == 64'd0);
    if (!r.div_zero) begin
      p = 64'd1048576 - {44'b0, rp};
      p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
      q = asr64(p, 13);
      w1 = asr64(p9 * q * q, 25);
      w2 = asr64(p8 * p, 19);
      p = asr64(p + w1 + w2, 8) + (p7 << 4);
      pa = div_trunc(p, 64'd256);
      r.press_pa = pa[31:0];
    end
    return r;
  endfunction

  // Check each strobed reading against the oldest prediction
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && done_o) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reading tc=%h tf=%h pa=%h z=%b", $time,
                 temperature_centi_o, fine_temperature_o, pressure_pa_o, divisor_zero_o);
      end else begin
        want = pending_readings.pop_front();
        if (want.div_zero) zero_divisors++;
        if (temperature_centi_o !== want.temp_centi) begin
          mismatches++;
          $display("%0t: temperature_centi expected %h got %h", $time,
                   want.temp_centi, temperature_centi_o);
        end
        if (fine_temperature_o !== want.fine_temp) begin
          mismatches++;
          $display("%0t: fine_temperature expected %h got %h", $time,
                   want.fine_temp, fine_temperature_o);
        end
        if (pressure_pa_o !== want.press_pa) begin
          mismatches++;
          $display("%0t: pressure_pa expected %h got %h", $time,
                   want.press_pa, pressure_pa_o);
        end
        if (divisor_zero_o !== want.div_zero) begin
          mismatches++;
          $display("%0t: divisor_zero expected %b got %b", $time,
                   want.div_zero, divisor_zero_o);
        end
      end
    end
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one request and record its prediction on acceptance
  task automatic send_request(input logic [19:0] rt, input logic [19:0] rp);
    start_i <= 1'b1;
    raw_temperature_i <= rt;
    raw_pressure_i <= rp;
    do @(posedge clk_i); while (busy_o);
    pending_readings.push_back(compensate(rt, rp));
    requests_sent++;
    if ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  // Hold off until every reading is in and the pipeline has emptied
  task automatic drain;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgTemp:      temp_cal = data[47:0];
      CfgPressLow:  press_cal_low = data;
      CfgPressHigh: press_cal_high = data;
      default:      press_cal_nine = data[15:0];
    endcase
  endtask

  task automatic load_cal(input logic [47:0] tc, input logic [63:0] pl,
                          input logic [63:0] ph, input logic [15:0] p9);
    drain();
    write_reg(CfgTemp, {16'h0, tc});
    write_reg(CfgPressLow, pl);
    write_reg(CfgPressHigh, ph);
    write_reg(CfgPressNine, {48'h0, p9});
  endtask

  task automatic load_typical;
    load_cal({16'hFC18, 16'd26435, 16'd27504},
             {16'd2855, 16'd3024, 16'hD643, 16'd36477},
             {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
  endtask

  // All-zero calibration after reset: divisor is always zero
  task automatic test_reset_defaults;
    send_request(20'h0, 20'h0);
    send_request(20'hFFFFF, 20'hFFFFF);
    send_request(20'd519888, 20'd415148);
  endtask

  task automatic test_typical_sensor;
    load_typical();
    send_request(20'd519888, 20'd415148);
    send_request(20'h0, 20'h0);
    send_request(20'hFFFFF, 20'hFFFFF);
    send_request(20'h0, 20'hFFFFF);
    send_request(20'hFFFFF, 20'h0);
    send_request(20'h55555, 20'hAAAAA);
  endtask

  task automatic test_coefficient_extremes;
    load_cal('1, '1, '1, 16'hFFFF);
    send_request(20'h0, 20'h0);
    send_request(20'hFFFFF, 20'hFFFFF);
    load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
             {4{16'h8000}}, 16'h8000);
    send_request(20'h0, 20'hFFFFF);
    send_request(20'hFFFFF, 20'h0);
    load_cal({16'h7FFF, 16'h7FFF, 16'h0}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1},
             {4{16'h7FFF}}, 16'h7FFF);
    send_request(20'h0, 20'h0);
    send_request(20'hFFFFF, 20'hFFFFF);
    // P1 of zero forces a zero divisor with live temperature fields
    load_cal({16'hFC18, 16'd26435, 16'd27504}, 64'h1234_5678_9ABC_0000, '1, 16'h1);
    send_request(20'd519888, 20'd415148);
    send_request(20'hFFFFF, 20'h0);
  endtask

  function automatic logic [15:0] nudge(input logic [15:0] v);
    return v + 16'($urandom_range(64, 0)) - 16'd32;
  endfunction

  // Random calibration: mostly near-realistic, some fully random, some P1 zero
  task automatic load_random_cal;
    int unsigned kind;
    logic [63:0] pl;
    kind = $urandom_range(9, 0);
    if (kind < 6) begin
      pl = {nudge(16'd2855), nudge(16'd3024), nudge(16'hD643), nudge(16'd36477)};
      if (kind == 5) pl[15:0] = '0;
      load_cal({nudge(16'hFC18), nudge(16'd26435), nudge(16'd27504)}, pl,
               {nudge(16'hC6F8), nudge(16'd15500), nudge(16'hFFF9), nudge(16'd140)},
               nudge(16'd6000));
    end else begin
      load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
               16'($urandom));
    end
  endtask

  task automatic test_random_phase(input int unsigned pct, input int unsigned count);
    idle_pct = pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 95 == 0) load_random_cal();
      if ($urandom_range(3, 0) != 0)
        send_request(20'($urandom_range(560000, 480000)),
                     20'($urandom_range(480000, 250000)));
      else
        send_request(20'($urandom), 20'($urandom));
    end
  endtask

  initial begin
    temp_cal = '0;
    press_cal_low = '0;
    press_cal_high = '0;
    press_cal_nine = '0;
    mismatches = 0;
    requests_sent = 0;
    readings_seen = 0;
    zero_divisors = 0;
    cycle_count = 0;
    idle_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_typical_sensor();
    test_coefficient_extremes();
    test_random_phase(0, 475);
    test_random_phase(60, 475);
    test_random_phase(6, 475);
    test_random_phase(0, 475);

    drain();
    $display("Covered %0d requests, %0d readings, %0d with a zero divisor, %0d mismatches",
             requests_sent, readings_seen, zero_divisors, mismatches);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
